// ----- hdl/rar_pkg.sv -----
// ----------------------------------------------------------------------------
// rar_pkg
// shared types and constants for the fraction add and reduce block
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int MagWidth = 64;
  localparam int CntWidth = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_t;

endpackage

// ----- hdl/rar_serial_mul.sv -----
// ----------------------------------------------------------------------------
// rar_serial_mul
// shift-and-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module rar_serial_mul import rar_pkg::*; #(
  parameter int OpWidth = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [OpWidth-1:0]  op_a,
  input  logic [OpWidth-1:0]  op_b,
  output logic                busy,
  output logic [MagWidth-1:0] prod
);

  logic [MagWidth-1:0] acc_r, mcand_r;
  logic [OpWidth-1:0]  mplier_r;
  logic [CntWidth-1:0] cnt_r;
  logic                busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r   <= 1'b1;
      cnt_r    <= CntWidth'(OpWidth);
      acc_r    <= '0;
      mcand_r  <= MagWidth'(op_a);
      mplier_r <= op_b;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_r <= acc_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
      cnt_r    <= cnt_r - 1'b1;
      if (cnt_r == CntWidth'(1)) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule

// ----- hdl/rar_serial_div.sv -----
// ----------------------------------------------------------------------------
// rar_serial_div
// restoring divider, one quotient bit per cycle, gives quotient and remainder
// ----------------------------------------------------------------------------
module rar_serial_div import rar_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MagWidth-1:0] dividend,
  input  logic [MagWidth-1:0] divisor,
  output logic                busy,
  output logic [MagWidth-1:0] quot,
  output logic [MagWidth-1:0] rem
);

  logic [MagWidth-1:0] q_r, r_r, d_r;
  logic [CntWidth-1:0] cnt_r;
  logic                busy_r;
  logic [MagWidth:0]   trial;
  logic [MagWidth:0]   shifted;

  assign shifted = {r_r, q_r[MagWidth-1]};
  assign trial   = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CntWidth'(MagWidth);
      q_r    <= dividend;
      r_r    <= '0;
      d_r    <= divisor;
    end else if (busy_r) begin
      if (!trial[MagWidth]) begin
        r_r <= trial[MagWidth-1:0];
        q_r <= {q_r[MagWidth-2:0], 1'b1};
      end else begin
        r_r <= shifted[MagWidth-1:0];
        q_r <= {q_r[MagWidth-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CntWidth'(1)) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

// ----- hdl/rational_add_reduce_top.sv -----
// ----------------------------------------------------------------------------
// rational_add_reduce_top
// adds two signed fractions and reduces the sum to lowest terms
// ----------------------------------------------------------------------------
// sequence: three cross products, then euclid steps and the two final divisions;
//   a zero denominator or zero sum goes straight from the add to the result
// throughput: one word in flight, the next is taken the cycle after the
//   result register loads; a stalled result holds the sequencer in ST_DONE
// reset: synchronous active-low rst_n returns the sequencer to idle, no
//   word held
module rational_add_reduce_top import rar_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_sum_num,
  output logic [61:0]        out_sum_den,
  output logic               out_div_zero
);

  localparam int W = OPERAND_WIDTH;

  // sign and magnitude of each operand (magnitude can be 2^(W-1), needs W bits)
  logic [W-1:0] an_mag_r, ad_mag_r, bn_mag_r, bd_mag_r;
  logic         an_neg_r, ad_neg_r, bn_neg_r, bd_neg_r;

  state_t state_r, state_nxt;
  logic [1:0] mstep_r, mstep_nxt;   // which cross product is running
  logic [MagWidth-1:0] p0_r, p1_r, den_r;
  logic [MagWidth-1:0] y_r, nm_r;   // euclid divisor, numerator magnitude
  logic       res_neg_r, p0_neg_r, p1_neg_r;
  logic       busy_wait_r;          // a unit was started last cycle

  logic signed [63:0] out_num_r;
  logic [61:0]        out_den_r;
  logic               out_dz_r, out_valid_r;

  // signed sum of the two cross products
  logic [MagWidth-1:0] sum_mag;
  logic                sum_neg;

  // multiplier hookup
  logic               mul_start, mul_busy;
  logic [W-1:0]       mul_a, mul_b;
  logic [MagWidth-1:0] mul_prod;
  // divider hookup
  logic               div_start, div_busy;
  logic [MagWidth-1:0] div_n, div_d, div_q, div_r;

  function automatic logic [W-1:0] mag_of(input logic [31:0] raw);
    logic [W-1:0] x;
    x = raw[W-1:0];
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  rar_serial_mul #(.OpWidth(W)) u_mul (
    .clk, .rst_n, .start(mul_start), .op_a(mul_a), .op_b(mul_b),
    .busy(mul_busy), .prod(mul_prod)
  );

  rar_serial_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_n), .divisor(div_d),
    .busy(div_busy), .quot(div_q), .rem(div_r)
  );

  logic in_acc, out_acc, unit_idle, out_free, out_load;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign unit_idle = !busy_wait_r && !mul_busy && !div_busy;
  // result register can take a word when empty or being read this edge
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_DONE) && out_free;

  // operand select for the shared multiplier: ad*bd, an*bd, bn*ad
  always_comb begin
    mul_a = ad_mag_r;
    mul_b = bd_mag_r;
    case (mstep_r)
      2'd1:    begin mul_a = an_mag_r; mul_b = bd_mag_r; end
      2'd2:    begin mul_a = bn_mag_r; mul_b = ad_mag_r; end
      default: begin mul_a = ad_mag_r; mul_b = bd_mag_r; end
    endcase
  end

  // divider operands: first euclid step, later steps, then the two reductions
  always_comb begin
    div_n = nm_r;
    div_d = y_r;
    case (state_r)
      ST_ADD:  begin div_n = sum_mag; div_d = den_r; end
      ST_GCD:  if (div_r != '0) begin
        div_n = y_r;
        div_d = div_r;
      end
      ST_DIVN: begin div_n = den_r; div_d = y_r; end
      default: ;
    endcase
  end

  // sum of the cross products as sign and magnitude
  always_comb begin
    if (p0_neg_r == p1_neg_r) begin
      sum_mag = p0_r + p1_r;
      sum_neg = p0_neg_r;
    end else if (p0_r >= p1_r) begin
      sum_mag = p0_r - p1_r;
      sum_neg = p0_neg_r;
    end else begin
      sum_mag = p1_r - p0_r;
      sum_neg = p1_neg_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mstep_nxt = mstep_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: if (in_acc) begin
        state_nxt = ST_MUL;
        mstep_nxt = 2'd0;
      end
      ST_MUL: if (unit_idle) begin
        // first pass just launches; middle passes collect and launch the next, the last collects
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd3) state_nxt = ST_ADD;
        else mul_start = 1'b1;
      end
      ST_ADD: begin
        if (den_r == '0 || sum_mag == '0) state_nxt = ST_DONE;
        else begin
          state_nxt = ST_GCD;
          div_start = 1'b1;
        end
      end
      ST_GCD: if (unit_idle) begin
        // zero remainder: y_r is the gcd, start reducing the numerator
        div_start = 1'b1;
        if (div_r == '0) state_nxt = ST_DIVN;
      end
      ST_DIVN: if (unit_idle) begin
        state_nxt = ST_DIVD;
        div_start = 1'b1;
      end
      ST_DIVD: if (unit_idle) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mstep_r     <= 2'd0;
      busy_wait_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mstep_r     <= mstep_nxt;
      busy_wait_r <= mul_start || div_start;
      out_valid_r <= out_load ? 1'b1 : (out_acc ? 1'b0 : out_valid_r);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      an_mag_r <= mag_of(in_a_num); an_neg_r <= in_a_num[W-1];
      ad_mag_r <= mag_of(in_a_den); ad_neg_r <= in_a_den[W-1];
      bn_mag_r <= mag_of(in_b_num); bn_neg_r <= in_b_num[W-1];
      bd_mag_r <= mag_of(in_b_den); bd_neg_r <= in_b_den[W-1];
    end
    if (state_r == ST_MUL && unit_idle) begin
      case (mstep_r)
        2'd1:    begin den_r <= mul_prod; end
        2'd2:    begin p0_r <= mul_prod; p0_neg_r <= an_neg_r ^ bd_neg_r; end
        2'd3:    begin p1_r <= mul_prod; p1_neg_r <= bn_neg_r ^ ad_neg_r; end
        default: ;
      endcase
    end
    if (state_r == ST_ADD) begin
      y_r       <= den_r;
      nm_r      <= sum_mag;
      res_neg_r <= sum_neg ^ ad_neg_r ^ bd_neg_r;
    end
    if (state_r == ST_GCD && unit_idle && div_r != '0) y_r <= div_r;
    if (state_r == ST_DIVN && unit_idle) nm_r <= div_q;
    if (state_r == ST_DIVD && unit_idle) den_r <= div_q;
    if (out_load) begin
      if (den_r == '0) begin
        out_num_r <= '0; out_den_r <= 62'd1; out_dz_r <= 1'b1;
      end else if (nm_r == '0) begin
        out_num_r <= '0; out_den_r <= 62'd1; out_dz_r <= 1'b0;
      end else begin
        out_num_r <= res_neg_r ? -$signed(nm_r) : $signed(nm_r);
        out_den_r <= den_r[61:0];
        out_dz_r  <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sum_num  = out_num_r;
  assign out_sum_den  = out_den_r;
  assign out_div_zero = out_dz_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall)
    else $error("input taken while busy");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_busy && div_busy))
    else $error("multiplier and divider both running");

  a_out_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_den_r != '0)
    else $error("zero denominator on output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_num_r) &&
      $stable(out_den_r) && $stable(out_dz_r))
    else $error("stalled result word changed");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fraction add and reduce block: a directed table
// of extremes and special cases, then random fraction pairs, each result word
// compared against a local model of the exact sum in lowest terms
// ----------------------------------------------------------------------------
module tb_top;

  localparam int OpWidth    = 32;
  localparam int CycleLimit = 50000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_a_num;
  logic signed [31:0] in_a_den;
  logic signed [31:0] in_b_num;
  logic signed [31:0] in_b_den;
  logic               out_valid;
  logic               out_stall;
  logic signed [63:0] out_sum_num;
  logic [61:0]        out_sum_den;
  logic               out_div_zero;

  // one expected result word
  typedef struct packed {
    logic [63:0] num;
    logic [61:0] den;
    logic        dz;
  } sum_t;

  // directed row: operands plus optional typed-in answer
  typedef struct {
    logic [31:0] an, ad, bn, bd;
    bit          has_ans;
    sum_t        ans;
  } row_t;

  sum_t   pending_sums[$];
  int     err_cnt;
  int     cycle_cnt;
  int     send_idle_pct;
  int     recv_idle_pct;

  rational_add_reduce_top #(.OPERAND_WIDTH(OpWidth)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_a_num     (in_a_num),
    .in_a_den     (in_a_den),
    .in_b_num     (in_b_num),
    .in_b_den     (in_b_den),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sum_num  (out_sum_num),
    .out_sum_den  (out_sum_den),
    .out_div_zero (out_div_zero)
  );

  // 10 unit clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sign and magnitude of an operand, read as signed at the operand width
  function automatic logic [63:0] op_mag(input logic [31:0] raw, output bit neg);
    logic [63:0] x;
    x = {32'd0, raw} & ((64'd1 << OpWidth) - 1);
    neg = x[OpWidth-1];
    op_mag = neg ? ((~x + 64'd1) & ((64'd1 << OpWidth) - 1)) : x;
  endfunction

  // exact sum a_num/a_den + b_num/b_den in lowest terms
  function automatic sum_t reduced_sum(input logic [31:0] an, ad, bn, bd);
    bit          san, sad, sbn, sbd, sp, sq, nneg, dneg;
    logic [63:0] man, mad, mbn, mbd, p, q, nm, dm, x, y, r;
    sum_t        s;
    man = op_mag(an, san);
    mad = op_mag(ad, sad);
    mbn = op_mag(bn, sbn);
    mbd = op_mag(bd, sbd);
    s = '{num: 64'd0, den: 62'd1, dz: 1'b0};
    dm = mad * mbd;
    dneg = sad ^ sbd;
    if (dm == 0) begin
      s.dz = 1'b1;
      return s;
    end
    p = man * mbd;
    sp = (san ^ sbd) && p != 0;
    q = mbn * mad;
    sq = (sbn ^ sad) && q != 0;
    if (sp == sq) begin
      nm = p + q;
      nneg = sp;
    end else if (p >= q) begin
      nm = p - q;
      nneg = sp;
    end else begin
      nm = q - p;
      nneg = sq;
    end
    if (nm == 0) return s;
    // euclid on magnitudes
    x = nm;
    y = dm;
    r = x % y;
    while (r != 0) begin
      x = y;
      y = r;
      r = x % y;
    end
    nm = nm / y;
    dm = dm / y;
    s.num = (nneg ^ dneg) ? (~nm + 64'd1) : nm;
    s.den = dm[61:0];
    return s;
  endfunction

  // drive one word and wait for it to be taken
  task automatic send_word(input logic [31:0] an, ad, bn, bd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    pending_sums.push_back(reduced_sum(an, ad, bn, bd));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // random operand biased toward small values, edges and full range
  function automatic logic [31:0] rand_op();
    int k;
    k = $urandom_range(9);
    case (k)
      0:       rand_op = 32'h8000_0000;
      1:       rand_op = 32'h7fff_ffff;
      2, 3:    rand_op = $urandom_range(20) - 10;
      4, 5:    rand_op = $urandom_range(2000) - 1000;
      default: rand_op = $urandom;
    endcase
  endfunction

  // receiver: random stall and the compare against the oldest expectation
  always @(posedge clk) begin
    sum_t e;
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_sums.size() == 0) begin
          $display("%0t: unexpected word exp none got num=%0d den=%0d dz=%0b",
                   $time, out_sum_num, out_sum_den, out_div_zero);
          err_cnt++;
        end else begin
          e = pending_sums.pop_front();
          if (out_sum_num !== e.num) begin
            $display("%0t: sum_num exp %0d got %0d", $time, $signed(e.num),
                     out_sum_num);
            err_cnt++;
          end
          if (out_sum_den !== e.den) begin
            $display("%0t: sum_den exp %0d got %0d", $time, e.den, out_sum_den);
            err_cnt++;
          end
          if (out_div_zero !== e.dz) begin
            $display("%0t: div_zero exp %0b got %0b", $time, e.dz, out_div_zero);
            err_cnt++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // cycle limit watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    sum_t e;
    int   n;
    err_cnt = 0;
    cycle_cnt = 0;
    send_idle_pct = 17;
    recv_idle_pct = 70;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_a_num = '0;
    in_a_den = '0;
    in_b_num = '0;
    in_b_den = '0;
    out_stall = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: zero denominators, zero sums, extremes
    rows.push_back('{32'd1, 32'd0, 32'd1, 32'd1, 1, '{64'd0, 62'd1, 1'b1}});
    rows.push_back('{32'd1, 32'd1, 32'd1, 32'd0, 1, '{64'd0, 62'd1, 1'b1}});
    rows.push_back('{32'd0, 32'd0, 32'd0, 32'd0, 1, '{64'd0, 62'd1, 1'b1}});
    rows.push_back('{32'd0, 32'd5, 32'd0, -32'sd7, 1, '{64'd0, 62'd1, 1'b0}});
    rows.push_back('{32'd3, 32'd4, -32'sd3, 32'd4, 1, '{64'd0, 62'd1, 1'b0}});
    rows.push_back('{32'd1, 32'd2, 32'd1, 32'd2, 1, '{64'd1, 62'd1, 1'b0}});
    rows.push_back('{32'd1, -32'sd2, 32'd0, 32'd1, 1, '{-64'sd1, 62'd2, 1'b0}});
    rows.push_back('{32'd1, 32'd3, 32'd1, 32'd6, 1, '{64'd1, 62'd2, 1'b0}});
    rows.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1,
                     '{64'd2, 62'd1, 1'b0}});
    rows.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1,
                     '{64'd2, 62'd1, 1'b0}});
    rows.push_back('{32'h80000000, 32'd1, 32'h80000000, 32'd1, 0, 'x});
    rows.push_back('{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0,
                     'x});
    rows.push_back('{32'd1, 32'h7fffffff, 32'd1, 32'h80000000, 0, 'x});
    rows.push_back('{-32'sd1, 32'h7fffffff, -32'sd1, 32'h7ffffffe, 0, 'x});
    rows.push_back('{32'hffffffff, 32'hffffffff, 32'd0, 32'h55555555, 0, 'x});
    rows.push_back('{32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa, 0,
                     'x});
    rows.push_back('{32'd7, -32'sd9, -32'sd5, 32'd12, 0, 'x});
    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.has_ans) begin
        e = reduced_sum(rw.an, rw.ad, rw.bn, rw.bd);
        if (e !== rw.ans) begin
          $display("%0t: table row %0d exp %h model %h", $time, i, rw.ans, e);
          err_cnt++;
        end
      end
      send_word(rw.an, rw.ad, rw.bn, rw.bd);
    end

    // random words in three idling phases
    for (n = 0; n < 1750; n++) begin
      if (n == 580) begin
        send_idle_pct = 70;
        recv_idle_pct = 17;
      end else if (n == 1160) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_word(rand_op(), ($urandom_range(40) == 0) ? 32'd0 : rand_op(),
                rand_op(), ($urandom_range(40) == 0) ? 32'd0 : rand_op());
    end
    in_valid <= 1'b0;

    // drain, then allow for a straggler word
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
